@@ src/button_longpress_calibration_ui_defines.svh @@
// Assertion macros shared by the button interface RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef BUTTON_LONGPRESS_CALIBRATION_UI_DEFINES_SVH
`define BUTTON_LONGPRESS_CALIBRATION_UI_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BLUC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define BLUC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) else $error(msg);

`endif

@@ src/bluc_pkg.sv @@
// Shared types, codes and helper functions for the button interface block.
// Used by bluc_core, bluc_fifo and the top level; depends on nothing.
package bluc_pkg;

  // Stream widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NOW_W      = 32;
  localparam int NUM_BTN    = 3;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int CNT_W   = 3;

  // Item kinds.
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Button indexes.
  localparam logic [1:0] BTN_CW     = 2'd0;
  localparam logic [1:0] BTN_SELECT = 2'd1;
  localparam logic [1:0] BTN_CCW    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SLOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MEDIUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FAST   = 3'd4;

  // Configuration reset values.
  localparam logic [31:0] COOLDOWN_RST    = 32'd50;
  localparam logic [31:0] LONGPRESS_RST   = 32'd1000;
  localparam logic [15:0] STEP_SLOW_RST   = 16'd100;
  localparam logic [15:0] STEP_MEDIUM_RST = 16'd400;
  localparam logic [15:0] STEP_FAST_RST   = 16'd1000;

  // Servo command codes.
  localparam logic [2:0] CMD_NONE          = 3'd0;
  localparam logic [2:0] CMD_GOTO          = 3'd1;
  localparam logic [2:0] CMD_RELATIVE      = 3'd2;
  localparam logic [2:0] CMD_CAPTURE_START = 3'd3;
  localparam logic [2:0] CMD_CAPTURE_END   = 3'd4;

  localparam logic signed [16:0] POS_ZERO        = 17'sd0;
  localparam logic signed [16:0] POS_CAPTURE_MAX = 17'sd65535;

  // UI modes.
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_CAL_OPEN  = 2'd1;
  localparam logic [1:0] MODE_CAL_CLOSE = 2'd2;

  // Speed indexes.
  localparam logic [1:0] SPEED_SLOW   = 2'd0;
  localparam logic [1:0] SPEED_MEDIUM = 2'd1;
  localparam logic [1:0] SPEED_FAST   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_PRESSED      = 3'd1,
    ST_RELEASED     = 3'd2,
    ST_LONG         = 3'd3,
    ST_PRESSED_IDLE = 3'd4
  } btn_state_t;

  typedef struct packed {
    logic              operation;
    logic [1:0]        button;
    logic              pin_level;
    logic [NOW_W-1:0]  now_tick;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cooldown;
    logic [31:0] long_hold;
    logic [15:0] step_slow;
    logic [15:0] step_medium;
    logic [15:0] step_fast;
  } cfg_t;

  typedef struct packed {
    logic               status;
    logic [2:0]         servo_command;
    logic signed [16:0] position_value;
    logic [1:0]         ui_mode;
    logic [1:0]         speed_index;
    logic               last_result;
  } res_word_t;

  // Up to two results produced by one check item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_word_t  r0;
    res_word_t  r1;
  } push_t;

  function automatic logic [1:0] mode_advance(input logic [1:0] m);
    logic [1:0] r;
    case (m)
      MODE_NORMAL:   r = MODE_CAL_OPEN;
      MODE_CAL_OPEN: r = MODE_CAL_CLOSE;
      default:       r = MODE_NORMAL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] speed_down(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      SPEED_SLOW:   r = SPEED_FAST;
      SPEED_MEDIUM: r = SPEED_SLOW;
      default:      r = SPEED_MEDIUM;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] speed_up(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      SPEED_SLOW:   r = SPEED_MEDIUM;
      SPEED_MEDIUM: r = SPEED_FAST;
      default:      r = SPEED_SLOW;
    endcase
    return r;
  endfunction

endpackage

@@ src/bluc_core.sv @@
// Button state, debounce, long-press and calibration logic for one item.
// Depends on bluc_pkg; feeds its results to the result queue.
module bluc_core import bluc_pkg::*; #(
  parameter int TICK_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  input  cfg_t     cfg,
  output push_t    push
);

  localparam int CW = (TICK_BITS > NOW_W) ? TICK_BITS : NOW_W;

  btn_state_t           states [NUM_BTN];
  btn_state_t           states_next [NUM_BTN];
  logic [TICK_BITS-1:0] last_edge [NUM_BTN];
  logic [TICK_BITS-1:0] last_edge_next [NUM_BTN];
  logic [1:0]           mode;
  logic [1:0]           mode_next;
  logic [1:0]           speed;
  logic [1:0]           speed_next;

  logic [CW-1:0]        now_ext;
  logic [TICK_BITS-1:0] now_t;
  logic [TICK_BITS-1:0] diff [NUM_BTN];
  logic [TICK_BITS-1:0] diff_sel;
  logic                 edge_hit;
  btn_state_t           s_prom [NUM_BTN];
  logic                 any_active;
  logic                 long_sel;
  logic [1:0]           mode_a;
  logic [1:0]           speed_a;
  logic [15:0]          step;
  logic                 move;
  logic signed [16:0]   move_pos;
  res_word_t            lp_res;
  res_word_t            mv_res;
  res_word_t            none_res;

  // Tick differences per button, modulo the tick width.
  always_comb begin
    now_ext = CW'(item.now_tick);
    now_t   = now_ext[TICK_BITS-1:0];
    for (int i = 0; i < NUM_BTN; i++) begin
      diff[i] = now_t - last_edge[i];
    end
  end

  // Edge acceptance: only known buttons whose cooldown has passed.
  always_comb begin
    case (item.button)
      BTN_CW:     diff_sel = diff[0];
      BTN_SELECT: diff_sel = diff[1];
      default:    diff_sel = diff[2];
    endcase
    edge_hit = (item.button != 2'd3) && (CW'(diff_sel) > CW'(cfg.cooldown));
  end

  // Long-press promotion and calibration decisions for a check item.
  always_comb begin
    for (int i = 0; i < NUM_BTN; i++) begin
      if ((states[i] == ST_PRESSED || states[i] == ST_PRESSED_IDLE) &&
          (CW'(diff[i]) > CW'(cfg.long_hold)))
        s_prom[i] = ST_LONG;
      else
        s_prom[i] = states[i];
    end
    any_active = 1'b0;
    for (int i = 0; i < NUM_BTN; i++) begin
      if (s_prom[i] != ST_IDLE && s_prom[i] != ST_PRESSED_IDLE) any_active = 1'b1;
    end
    long_sel = (s_prom[1] == ST_LONG);
    mode_a   = long_sel ? mode_advance(mode) : mode;
    speed_a  = long_sel ? speed_down(speed) : speed;
    case (speed_a)
      SPEED_SLOW:   step = cfg.step_slow;
      SPEED_MEDIUM: step = cfg.step_medium;
      default:      step = cfg.step_fast;
    endcase
    move     = (mode_a != MODE_NORMAL) &&
               (s_prom[0] == ST_PRESSED || s_prom[2] == ST_PRESSED);
    move_pos = (s_prom[0] == ST_PRESSED) ? $signed({1'b0, step})
                                         : -$signed({1'b0, step});
  end

  // Next state of buttons, edge ticks, mode and speed.
  always_comb begin
    states_next    = states;
    last_edge_next = last_edge;
    mode_next      = mode;
    speed_next     = speed;
    if (item.operation == OP_EDGE) begin
      if (edge_hit) begin
        for (int i = 0; i < NUM_BTN; i++) begin
          if (item.button == 2'(i)) begin
            states_next[i]    = item.pin_level ? ST_RELEASED : ST_PRESSED;
            last_edge_next[i] = now_t;
          end
        end
      end
    end else if (!any_active) begin
      states_next = s_prom;
    end else begin
      mode_next  = mode_a;
      speed_next = speed_a;
      if (mode_a != MODE_NORMAL && !move && s_prom[1] == ST_PRESSED)
        speed_next = speed_up(speed_a);
      // Age the buttons once the check has used them.
      for (int i = 0; i < NUM_BTN; i++) begin
        case (s_prom[i])
          ST_PRESSED:  states_next[i] = ST_PRESSED_IDLE;
          ST_LONG:     states_next[i] = ST_IDLE;
          ST_RELEASED: states_next[i] = ST_IDLE;
          default:     states_next[i] = s_prom[i];
        endcase
      end
    end
  end

  // Result words of a check item.
  always_comb begin
    lp_res                = '0;
    lp_res.status         = 1'b1;
    lp_res.ui_mode        = mode_next;
    lp_res.speed_index    = speed_next;
    case (mode_a)
      MODE_CAL_OPEN: begin
        lp_res.servo_command  = CMD_GOTO;
        lp_res.position_value = POS_ZERO;
      end
      MODE_CAL_CLOSE: begin
        lp_res.servo_command  = CMD_CAPTURE_START;
        lp_res.position_value = POS_CAPTURE_MAX;
      end
      default: begin
        lp_res.servo_command  = CMD_CAPTURE_END;
        lp_res.position_value = POS_ZERO;
      end
    endcase
    lp_res.last_result    = !move;

    mv_res                = '0;
    mv_res.status         = 1'b1;
    mv_res.servo_command  = CMD_RELATIVE;
    mv_res.position_value = move_pos;
    mv_res.ui_mode        = mode_next;
    mv_res.speed_index    = speed_next;
    mv_res.last_result    = 1'b1;

    none_res              = '0;
    none_res.status       = any_active;
    none_res.servo_command = CMD_NONE;
    none_res.position_value = POS_ZERO;
    none_res.ui_mode      = mode_next;
    none_res.speed_index  = speed_next;
    none_res.last_result  = 1'b1;

    push    = '0;
    push.r1 = mv_res;
    if (fire && item.operation == OP_CHECK) begin
      if (any_active && long_sel) begin
        push.r0    = lp_res;
        push.count = move ? 2'd2 : 2'd1;
      end else if (any_active && move) begin
        push.r0    = mv_res;
        push.count = 2'd1;
      end else begin
        push.r0    = none_res;
        push.count = 2'd1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BTN; i++) begin
        states[i]    <= ST_IDLE;
        last_edge[i] <= '0;
      end
      mode  <= MODE_NORMAL;
      speed <= SPEED_MEDIUM;
    end else if (fire) begin
      states    <= states_next;
      last_edge <= last_edge_next;
      mode      <= mode_next;
      speed     <= speed_next;
    end
  end

endmodule

@@ src/bluc_fifo.sv @@
// Result queue: takes up to two result words a cycle, delivers one a cycle while out_ready is high.
// Depends on bluc_pkg and the assertion macros header.
`include "button_longpress_calibration_ui_defines.svh"

module bluc_fifo import bluc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output res_word_t out_res
);

  res_word_t        q [Q_DEPTH];
  logic [Q_AW-1:0]  wr;
  logic [Q_AW-1:0]  rd;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign out_valid  = (count != '0);
  assign out_res    = q[rd];
  assign pop        = out_valid && out_ready;
  assign room       = (count <= CNT_W'(Q_DEPTH - 2));
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  // Storage writes; the second word of a pair lands one slot further.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) q[wr] <= push.r0;
    if (push.count == 2'd2) q[wr + 1'b1] <= push.r1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + Q_AW'(push.count);
      rd    <= rd + Q_AW'(pop);
      count <= count_next;
    end
  end

  `BLUC_ASSERT(a_q_bound, clk, rst, (count <= CNT_W'(Q_DEPTH)), "result queue overfilled")
  `BLUC_ASSERT(a_q_room, clk, rst, ((push.count != 2'd0) |-> room), "push without room for a pair")
  `BLUC_ASSERT_NEXT(a_q_count, clk, rst, 1'b1, (count == $past(count) + CNT_W'($past(push.count)) - CNT_W'($past(pop))), "fill count out of step")

endmodule

@@ src/button_longpress_calibration_ui.sv @@
// Top level of the three-button debounce, long-press and calibration interface.
// Depends on bluc_pkg, bluc_core and bluc_fifo.
//
// Usage:
//   Items enter on the s_ stream: s_tuser holds the kind (edge or check),
//   s_tdata the button, the pin level and the current tick. Edge items only
//   update the button state and give no word. A check item gives one or two
//   result words on the m_ stream; m_tlast marks the final word of a check.
//   Configuration registers are written through cfg_valid/cfg_index/cfg_data; the user must write
//   them only while no item is in flight; the block does not enforce it. cfg_ready is always high.
// Timing:
//   An accepted item waits in the input register and is processed from there once the
//   queue has room for its words; its words are written into the queue registers and
//   offered on m_tvalid from there. One item is taken each cycle unless a check waits
//   for room. A check that gives two words takes two queue slots; the four-word queue
//   absorbs this, and input stalls only when fewer than two slots are free.
// Reset (rst, synchronous): buttons idle, edge ticks zero, normal mode, medium
//   speed, registers at their defaults, queue empty. No clearing pass is needed.
// Stall: when m_tready is low, words stay in the queue and s_tready drops
//   once the queue cannot take another pair while a check item waits.
module button_longpress_calibration_ui import bluc_pkg::*; #(
  parameter int TICK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // button[1:0], pin_level[2], now_tick[34:3]
  input  logic [0:0]            s_tuser,   // operation[0]
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status[0], servo_command[3:1],
                                           // position_value[20:4], ui_mode[22:21],
                                           // speed_index[24:23]
  output logic                  m_tlast,   // last_result
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      in_v;
  in_item_t  in_item;
  logic      fire;
  logic      room;
  cfg_t      cfg;
  push_t     push;
  res_word_t out_res;

  // An item in the input register is processed when the queue can take its words.
  assign fire     = in_v && (in_item.operation == OP_EDGE || room);
  assign s_tready = !in_v || fire;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation <= s_tuser[0];
      in_item.button    <= s_tdata[1:0];
      in_item.pin_level <= s_tdata[2];
      in_item.now_tick  <= s_tdata[34:3];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooldown    <= COOLDOWN_RST;
      cfg.long_hold   <= LONGPRESS_RST;
      cfg.step_slow   <= STEP_SLOW_RST;
      cfg.step_medium <= STEP_MEDIUM_RST;
      cfg.step_fast   <= STEP_FAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COOLDOWN:    cfg.cooldown    <= cfg_data;
        REG_LONGPRESS:   cfg.long_hold   <= cfg_data;
        REG_STEP_SLOW:   cfg.step_slow   <= cfg_data[15:0];
        REG_STEP_MEDIUM: cfg.step_medium <= cfg_data[15:0];
        REG_STEP_FAST:   cfg.step_fast   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bluc_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .push (push)
  );

  bluc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Result word packing.
  assign m_tdata = {7'd0, out_res.speed_index, out_res.ui_mode,
                    out_res.position_value, out_res.servo_command, out_res.status};
  assign m_tlast = out_res.last_result;

endmodule

@@ tb/calib_ui_scoreboard_pkg.sv @@
// Scoreboard for the button long-press and calibration interface.
// Holds its own predictor of the button, mode and speed state.
// Depends on bluc_pkg for the item, result and state types.
package calib_ui_scoreboard_pkg;
  import bluc_pkg::*;

  class calib_ui_scoreboard;
    // Predicted block state and register copies.
    btn_state_t       btn_st[NUM_BTN];
    logic [NOW_W-1:0] edge_tick[NUM_BTN];
    int               mode;
    int               speed;
    logic [31:0]      cooldown;
    logic [31:0]      longpress;
    logic [15:0]      step_tbl[3];

    // Result words still owed by the block, oldest first.
    res_word_t        expected_q[$];

    // Counters for the verdict and the summary.
    int               errors;
    int               words_checked;
    int               checks;
    int               edges_taken;
    int               idle_checks;
    int               cmd_seen[5];

    function new();
      for (int i = 0; i < NUM_BTN; i++) begin
        btn_st[i] = ST_IDLE;
        edge_tick[i] = '0;
      end
      mode = MODE_NORMAL;
      speed = SPEED_MEDIUM;
      cooldown = COOLDOWN_RST;
      longpress = LONGPRESS_RST;
      step_tbl[0] = STEP_SLOW_RST;
      step_tbl[1] = STEP_MEDIUM_RST;
      step_tbl[2] = STEP_FAST_RST;
    endfunction

    // Mirror a register write; unknown indexes change nothing.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COOLDOWN:    cooldown = data;
        REG_LONGPRESS:   longpress = data;
        REG_STEP_SLOW:   step_tbl[0] = data[15:0];
        REG_STEP_MEDIUM: step_tbl[1] = data[15:0];
        REG_STEP_FAST:   step_tbl[2] = data[15:0];
        default: ;
      endcase
    endfunction

    function res_word_t make_word(logic [2:0] cmd, logic signed [16:0] pos);
      res_word_t w;
      w = '0;
      w.status = 1'b1;
      w.servo_command = cmd;
      w.position_value = pos;
      return w;
    endfunction

    // Work out the result words of one accepted item.
    function void note_item(in_item_t it);
      res_word_t          words[2];
      int                 n;
      logic [NOW_W-1:0]   held;
      logic signed [16:0] step;
      bit                 active;
      n = 0;
      active = 1'b0;

      // An edge only moves the button state, and only past the cooldown.
      if (it.operation == OP_EDGE) begin
        if (it.button < NUM_BTN) begin
          held = it.now_tick - edge_tick[it.button];
          if (held > cooldown) begin
            btn_st[it.button] = it.pin_level ? ST_RELEASED : ST_PRESSED;
            edge_tick[it.button] = it.now_tick;
            edges_taken++;
          end
        end
        return;
      end
      checks++;

      // Promote buttons held past the long-press time.
      for (int i = 0; i < NUM_BTN; i++) begin
        held = it.now_tick - edge_tick[i];
        if ((btn_st[i] == ST_PRESSED || btn_st[i] == ST_PRESSED_IDLE) && held > longpress)
          btn_st[i] = ST_LONG;
        if (btn_st[i] != ST_IDLE && btn_st[i] != ST_PRESSED_IDLE)
          active = 1'b1;
      end

      if (!active) begin
        words[0] = make_word(CMD_NONE, POS_ZERO);
        words[0].status = 1'b0;
        n = 1;
        idle_checks++;
      end else begin
        // A long select steps the mode and lowers the speed.
        if (btn_st[BTN_SELECT] == ST_LONG) begin
          speed = (speed + 2) % 3;
          mode = (mode + 1) % 3;
          case (mode)
            MODE_CAL_OPEN:  words[n] = make_word(CMD_GOTO, POS_ZERO);
            MODE_CAL_CLOSE: words[n] = make_word(CMD_CAPTURE_START, POS_CAPTURE_MAX);
            default:        words[n] = make_word(CMD_CAPTURE_END, POS_ZERO);
          endcase
          n++;
        end
        // In calibration, a fresh turn moves the servo and a short select speeds up.
        if (mode != MODE_NORMAL) begin
          step = {1'b0, step_tbl[speed]};
          if (btn_st[BTN_CW] == ST_PRESSED) begin
            words[n] = make_word(CMD_RELATIVE, step);
            n++;
          end else if (btn_st[BTN_CCW] == ST_PRESSED) begin
            words[n] = make_word(CMD_RELATIVE, -step);
            n++;
          end else if (btn_st[BTN_SELECT] == ST_PRESSED) begin
            speed = (speed + 1) % 3;
          end
        end
        if (n == 0) begin
          words[0] = make_word(CMD_NONE, POS_ZERO);
          n = 1;
        end
        // Age the button states.
        for (int i = 0; i < NUM_BTN; i++) begin
          if (btn_st[i] == ST_PRESSED)
            btn_st[i] = ST_PRESSED_IDLE;
          else if (btn_st[i] == ST_LONG || btn_st[i] == ST_RELEASED)
            btn_st[i] = ST_IDLE;
        end
      end

      // Mode and speed are reported as they stand after the whole item.
      for (int i = 0; i < n; i++) begin
        words[i].ui_mode = mode[1:0];
        words[i].speed_index = speed[1:0];
        words[i].last_result = (i == n - 1);
        cmd_seen[words[i].servo_command]++;
        expected_q.push_back(words[i]);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result word with the oldest expectation.
    task check_word(res_word_t got);
      res_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %h arrived with nothing pending", got));
        return;
      end
      want = expected_q.pop_front();
      words_checked++;
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.servo_command != want.servo_command)
        report($sformatf("servo_command %0d, want %0d", got.servo_command, want.servo_command));
      if (got.position_value != want.position_value)
        report($sformatf("position_value %0d, want %0d", got.position_value,
                         want.position_value));
      if (got.ui_mode != want.ui_mode)
        report($sformatf("ui_mode %0d, want %0d", got.ui_mode, want.ui_mode));
      if (got.speed_index != want.speed_index)
        report($sformatf("speed_index %0d, want %0d", got.speed_index, want.speed_index));
      if (got.last_result != want.last_result)
        report($sformatf("tlast %0d, want %0d", got.last_result, want.last_result));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for button_longpress_calibration_ui.
// Drives edge and check words, changes settings between phases and checks
// every result word against calib_ui_scoreboard_pkg; needs bluc_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bluc_pkg::*;
  import calib_ui_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int NUM_PHASES   = 7;
  localparam int PAD_W        = IN_DATA_W - NOW_W - 3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  calib_ui_scoreboard    sb;
  int                    tx_idle_pct = 25;
  int                    rx_idle_pct = 50;
  int                    hold_req = 0;
  int                    hold_left = 0;
  int                    cycle_cnt = 0;
  int                    items_sent = 0;
  logic [31:0]           tick_now = '0;
  logic [31:0]           cur_cool = COOLDOWN_RST;
  logic [31:0]           cur_lp = LONGPRESS_RST;

  button_longpress_calibration_ui u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watch all three channels at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        sb.note_item(in_item_t'{s_tuser[0], s_tdata[1:0], s_tdata[2], s_tdata[NOW_W+2:3]});
      if (m_tvalid && m_tready)
        sb.check_word(res_word_t'{m_tdata[0], m_tdata[3:1], m_tdata[20:4], m_tdata[22:21],
                                  m_tdata[24:23], m_tlast});
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed.", cycle_cnt, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word and hold it until taken; valid stays high afterwards.
  task automatic send_item(input logic op, input logic [1:0] btn, input logic lvl,
                           input logic [31:0] tick);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{PAD_W{1'b0}}, tick, lvl, btn};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_check(input logic [31:0] tick);
    send_item(OP_CHECK, 2'($urandom), 1'($urandom), tick);
  endtask

  // Let every owed word arrive, then allow for the pipeline latency.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // New settings only once the block has gone quiet.
  task automatic load_settings(input logic [31:0] cool, input logic [31:0] lp,
                               input logic [15:0] s0, input logic [15:0] s1,
                               input logic [15:0] s2);
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait_drained();
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_LONGPRESS, lp);
    write_reg(REG_STEP_SLOW, {16'($urandom), s0});
    write_reg(REG_STEP_MEDIUM, {16'($urandom), s1});
    write_reg(REG_STEP_FAST, {16'($urandom), s2});
    write_reg(CFG_IDX_W'(REG_STEP_FAST + $urandom_range(1, 3)), $urandom);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cur_cool = cool;
    cur_lp = lp;
  endtask

  // Press, a few checks, often a long hold with a turn, then release.
  task automatic press_sequence();
    logic [1:0] held_btn;
    logic [1:0] turn_btn;
    int         pick;
    pick = $urandom_range(0, 3);
    held_btn = (pick == 3) ? BTN_SELECT : 2'(pick);
    tick_now += cur_cool + 1 + $urandom_range(0, 20);
    send_item(OP_EDGE, held_btn, 1'b0, tick_now);
    repeat ($urandom_range(1, 3)) begin
      tick_now += $urandom_range(0, 40);
      send_check(tick_now);
    end
    if ($urandom_range(0, 2) != 0) begin
      tick_now += cur_lp + $urandom_range(1, 30);
      if ($urandom_range(0, 1) != 0) begin
        turn_btn = ($urandom_range(0, 1) != 0) ? BTN_CW : BTN_CCW;
        send_item(OP_EDGE, turn_btn, 1'b0, tick_now);
      end
      send_check(tick_now);
    end
    tick_now += cur_cool + 1 + $urandom_range(0, 20);
    send_item(OP_EDGE, held_btn, 1'b1, tick_now);
    tick_now += $urandom_range(0, 10);
    send_check(tick_now);
  endtask

  // Any field value at all, ticks often far off.
  task automatic noise_item();
    logic [31:0] t;
    t = ($urandom_range(0, 1) != 0) ? $urandom : tick_now + $urandom_range(0, 3000);
    send_item(1'($urandom), 2'($urandom), 1'($urandom), t);
  endtask

  initial begin
    int goal;
    int n_items;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk at reset settings: idle check, ignored and debounced edges,
    // plain activity, long select with a turn, both turn directions, select
    // speed-up, all three mode steps and tick wrap-around.
    send_check(32'd0);
    send_item(OP_EDGE, 2'd3, 1'b0, 32'd500);
    send_check(32'd500);
    send_item(OP_EDGE, BTN_CW, 1'b0, 32'd30);
    send_item(OP_EDGE, BTN_CW, 1'b0, 32'd100);
    send_check(32'd120);
    send_item(OP_EDGE, BTN_CW, 1'b1, 32'd200);
    send_check(32'd210);
    send_item(OP_EDGE, BTN_SELECT, 1'b0, 32'd300);
    send_check(32'd310);
    send_item(OP_EDGE, BTN_CW, 1'b0, 32'd1350);
    send_check(32'd1400);
    send_item(OP_EDGE, BTN_CCW, 1'b0, 32'd1500);
    send_check(32'd1500);
    send_item(OP_EDGE, BTN_SELECT, 1'b1, 32'd1600);
    send_check(32'd1600);
    send_item(OP_EDGE, BTN_SELECT, 1'b0, 32'd1700);
    send_check(32'd1700);
    send_check(32'd2800);
    send_item(OP_EDGE, BTN_CW, 1'b0, 32'd2900);
    send_check(32'd2900);
    send_item(OP_EDGE, BTN_SELECT, 1'b0, 32'd3000);
    send_check(32'd4100);
    send_item(OP_EDGE, BTN_CW, 1'b0, 32'hFFFF_FFF0);
    send_item(OP_EDGE, BTN_CW, 1'b1, 32'hFFFF_FFFF);
    send_check(32'h0000_0010);

    // Random phases, each with its own settings and idle pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 50 : 0;
      rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 25 : 0;
      n_items = 300;
      case (ph)
        0: begin
          load_settings(32'd0, 32'd0, 16'd0, 16'hFFFF, 16'd1);
          n_items = 250;
        end
        1: load_settings(COOLDOWN_RST, LONGPRESS_RST, STEP_SLOW_RST, STEP_MEDIUM_RST,
                         STEP_FAST_RST);
        2: load_settings(32'd7, 32'd120, 16'($urandom), 16'($urandom), 16'($urandom));
        3: begin
          load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          n_items = 60;
        end
        4: load_settings(32'd3, 32'd40, 16'd1, 16'd2, 16'd3);
        5: begin
          load_settings(32'd20, 32'd200, 16'($urandom), 16'($urandom), 16'($urandom));
          // Long receiver hold-off so the result queue fills and input stalls.
          hold_req = 1;
        end
        default: load_settings(32'd0, 32'd5, 16'hFFFF, 16'd0, 16'h8000);
      endcase
      tick_now = $urandom;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
        if ($urandom_range(0, 99) == 0)
          tick_now = $urandom;
        if ($urandom_range(0, 9) < 7)
          press_sequence();
        else
          noise_item();
      end
    end

    s_tvalid <= 1'b0;
    @(negedge clk);
    wait_drained();

    $display("Run covered %0d input words (%0d checks, %0d edges taken), %0d results.",
             items_sent, sb.checks, sb.edges_taken, sb.words_checked);
    $display("Commands: %0d none (%0d idle), %0d goto, %0d relative, %0d start, %0d end.",
             sb.cmd_seen[CMD_NONE], sb.idle_checks, sb.cmd_seen[CMD_GOTO],
             sb.cmd_seen[CMD_RELATIVE], sb.cmd_seen[CMD_CAPTURE_START],
             sb.cmd_seen[CMD_CAPTURE_END]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
